[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// operation codes, payload structs and the default datapath width
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int DefWidth = 32;

    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SUB  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_NEG  = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               zero_den;
        logic               overflow;
    } rau_out_t;

endpackage

[rtl/rau_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider: shared restoring divider
// one quotient bit per cycle, gives quotient and remainder of unsigned words
// ----------------------------------------------------------------------------
module rau_divider
    import rau_pkg::*;
#(
    parameter int W = DefWidth
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, r_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg, done_reg;
    logic [W:0]    trial;

    // shift one dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!trial[W])
            begin
                r_reg <= trial[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[W-2:0], q_reg[W-1]};
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

[rtl/rational_arith_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit: signed rational arithmetic with gcd reduction
// cross or straight multiplies two fractions (none for negate, normalize),
// reduces by a euclid gcd on a shared divider, sign moved to the numerator
// ----------------------------------------------------------------------------
// usage:
//   raise start with a beat on in_data while busy is low; the beat is taken
//   at that edge and busy rises at once
//   the block forms the raw numerator and denominator with one shared
//   multiplier (up to three products, one per cycle), then runs euclid's
//   gcd on one shared restoring divider, one quotient bit per cycle
//   each euclid step is one division on the divider; the gcd needs up to about
//   1.44*WIDTH steps in the worst case and typically a handful, then two
//   more divisions by the gcd give the reduced fraction
//   the time to a result depends on the data: add and subtract form three
//   products and a sum, multiply and divide two products, and negate and
//   normalize none, before the gcd
//   the result beat on out_data is flagged by done, high for exactly one
//   cycle; the receiver cannot stall, so it must take it then
//   busy is already low in the done cycle, so the next beat can be taken at
//   its closing edge; reset clears the sequencer, nothing is left in flight
// ----------------------------------------------------------------------------
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = DefWidth
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  rau_in_t  in_data,
    output logic     busy,
    output logic     done,
    output rau_out_t out_data
);

    localparam int W = WIDTH;
    localparam logic [W-1:0] TOP = {1'b1, {(W-1){1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_PREP = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_GW   = 4'd7;
    localparam logic [3:0] S_QN   = 4'd8;
    localparam logic [3:0] S_QNW  = 4'd9;
    localparam logic [3:0] S_QDW  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]   state_reg;
    logic [2:0]   kind_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] p_reg, num_reg, den_reg;
    logic [W-1:0] gx_reg, gy_reg, mn_reg, md_reg, qn_reg;
    logic         ovf_reg, zf_reg, neg_reg;
    logic         done_reg;
    rau_out_t     out_reg;

    // sign extended loads and their range check
    function automatic logic [W-1:0] cut(input logic [31:0] v);
        return W'($signed(v));
    endfunction

    function automatic logic fits(input logic [31:0] v);
        logic [63:0] sv;
        logic [63:0] wv;
        sv = 64'($signed(v));
        wv = 64'($signed(cut(v)));
        return sv == wv;
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // shared multiplier
    logic [W-1:0]     mx, my;
    logic [2*W-1:0]   prod;
    logic             prod_ovf;
    always_comb
    begin
        mx = an_reg;
        my = bd_reg;
        unique case (state_reg)
            S_M0:    begin mx = an_reg; my = (kind_reg == KIND_MUL) ? bn_reg : bd_reg; end
            S_M1:    begin mx = bn_reg; my = ad_reg; end
            default: begin mx = ad_reg; my = (kind_reg == KIND_DIV) ? bn_reg : bd_reg; end
        endcase
        prod     = (2*W)'($signed(mx) * $signed(my));
        prod_ovf = prod != {{W{prod[W-1]}}, prod[W-1:0]};
    end

    // shared divider
    logic         dv_go, dv_done;
    logic [W-1:0] dv_a, dv_b, dv_q, dv_r;

    rau_divider #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (dv_go),
        .dividend (dv_a),
        .divisor  (dv_b),
        .done     (dv_done),
        .quot     (dv_q),
        .rem      (dv_r)
    );

    always_comb
    begin
        dv_go = 1'b0;
        dv_a  = gx_reg;
        dv_b  = gy_reg;
        unique case (state_reg)
            S_GCD:   dv_go = gy_reg != '0;
            S_QN:    begin dv_go = 1'b1; dv_a = mn_reg; dv_b = gx_reg; end
            S_QNW:   begin dv_go = dv_done; dv_a = md_reg; dv_b = gx_reg; end
            default: dv_go = 1'b0;
        endcase
    end

    logic [W-1:0] sum, negq, rn;
    logic         sum_ovf;
    logic [W-1:0] q_sel;
    always_comb
    begin
        q_sel   = (kind_reg == KIND_SUB) ? (~num_reg + 1'b1) : num_reg;
        sum     = p_reg + q_sel;
        sum_ovf = (p_reg[W-1] == q_sel[W-1]) && (sum[W-1] != p_reg[W-1]);
        negq    = ~an_reg + 1'b1;
        rn      = neg_reg ? (~qn_reg + 1'b1) : qn_reg;
    end

    logic [63:0] rn_ext;
    assign rn_ext = 64'($signed(rn));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:  if (start) state_reg <= S_M0;
                S_M0:    state_reg <= (kind_reg == KIND_NEG || kind_reg > KIND_DIV)
                                      ? S_PREP
                                      : ((kind_reg == KIND_ADD || kind_reg == KIND_SUB)
                                         ? S_M1 : S_M2);
                S_M1:    state_reg <= S_M2;
                S_M2:    state_reg <= (kind_reg == KIND_ADD || kind_reg == KIND_SUB)
                                      ? S_SUM : S_PREP;
                S_SUM:   state_reg <= S_PREP;
                S_PREP:  state_reg <= S_GCD;
                S_GCD:   state_reg <= (gy_reg == '0) ? S_QN : S_GW;
                S_GW:    if (dv_done) state_reg <= S_GCD;
                S_QN:    state_reg <= S_QNW;
                S_QNW:   if (dv_done) state_reg <= S_QDW;
                S_QDW:   if (dv_done) state_reg <= S_OUT;
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    kind_reg <= in_data.kind;
                    an_reg   <= cut(in_data.a_num);
                    ad_reg   <= cut(in_data.a_den);
                    bn_reg   <= cut(in_data.b_num);
                    bd_reg   <= cut(in_data.b_den);
                    ovf_reg  <= !(fits(in_data.a_num) && fits(in_data.a_den)
                                  && fits(in_data.b_num) && fits(in_data.b_den));
                end
            S_M0:
            begin
                if (kind_reg == KIND_NEG)
                begin
                    num_reg <= negq;
                    den_reg <= ad_reg;
                    if (an_reg == TOP) ovf_reg <= 1'b1;
                end
                else if (kind_reg > KIND_DIV)
                begin
                    num_reg <= an_reg;
                    den_reg <= ad_reg;
                end
                else
                begin
                    p_reg   <= prod[W-1:0];
                    num_reg <= prod[W-1:0];
                    if (prod_ovf) ovf_reg <= 1'b1;
                end
            end
            S_M1:
            begin
                // negation of the cross product only overflows at the top value
                num_reg <= prod[W-1:0];
                if (prod_ovf || (kind_reg == KIND_SUB && prod[W-1:0] == TOP))
                    ovf_reg <= 1'b1;
            end
            S_M2:
            begin
                den_reg <= prod[W-1:0];
                if (prod_ovf) ovf_reg <= 1'b1;
            end
            S_SUM:
            begin
                num_reg <= sum;
                if (sum_ovf) ovf_reg <= 1'b1;
            end
            S_PREP:
            begin
                zf_reg  <= den_reg == '0;
                neg_reg <= num_reg[W-1] != ((den_reg == '0) ? 1'b0 : den_reg[W-1]);
                mn_reg  <= mag(num_reg);
                md_reg  <= (den_reg == '0) ? W'(1) : mag(den_reg);
                gx_reg  <= mag(num_reg);
                gy_reg  <= (den_reg == '0) ? W'(1) : mag(den_reg);
            end
            S_GW:
                if (dv_done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= dv_r;
                end
            S_QNW:
                if (dv_done) qn_reg <= dv_q;
            S_QDW:
                if (dv_done)
                begin
                    out_reg.res_num  <= rn_ext[31:0];
                    out_reg.res_den  <= 31'(dv_q);
                    out_reg.zero_den <= zf_reg;
                    out_reg.overflow <= ovf_reg
                        || (!neg_reg && qn_reg == TOP)
                        || (rn_ext != {{32{rn_ext[31]}}, rn_ext[31:0]})
                        || dv_q >= TOP
                        || (64'(dv_q) > 64'h7FFF_FFFF);
                end
            default: ;
        endcase
    end

    assign busy     = state_reg != S_IDLE;
    assign done     = done_reg;
    assign out_data = out_reg;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression of rational_arith_unit
// a short table of directed fractions is sent first, then random fractions of
// mixed shapes with random idle gaps; every result beat is checked field by
// field against its typed table value or a fraction reduction model in this bench
// ----------------------------------------------------------------------------
module testbench;
    import rau_pkg::*;

    localparam logic [2:0] KIND_NORM  = 3'd5;
    localparam int         RandItems  = 1900;
    localparam longint     CycleLimit = 16000000;
    localparam int         DrainWait  = 2000;

    typedef struct packed {
        rau_in_t  stim;
        logic     typed;
        rau_out_t want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    rau_in_t  in_data;
    logic     busy;
    logic     done;
    rau_out_t out_data;

    rau_out_t expected_fracs[$];
    longint   cycles;
    int       mismatches;
    int       beats_in;
    int       beats_out;
    int       zero_den_seen;
    int       overflow_seen;

    rational_arith_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_data  (in_data),
        .busy     (busy),
        .done     (done),
        .out_data (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // wrap a value to 32-bit two's complement, flag if it changed
    function automatic longint wrap32(input longint v, inout logic ovf);
        longint w;
        w = longint'(signed'(v[31:0]));
        if (w != v)
            ovf = 1'b1;
        return w;
    endfunction

    function automatic longint add32(input longint x, input longint y, inout logic ovf);
        longint s;
        logic   dummy;
        dummy = 1'b0;
        s = wrap32(x + y, dummy);
        if ((x < 0) == (y < 0) && (s < 0) != (x < 0))
            ovf = 1'b1;
        return s;
    endfunction

    function automatic longint neg32(input longint x, inout logic ovf);
        longint n;
        logic   dummy;
        dummy = 1'b0;
        n = wrap32(-x, dummy);
        if (x != 0 && n == x)
            ovf = 1'b1;
        return n;
    endfunction

    // cross or straight multiply, reduce by the gcd of magnitudes, sign onto numerator
    function automatic rau_out_t reduce_fraction(input rau_in_t s);
        rau_out_t r;
        logic     ovf;
        logic     zf;
        longint   an, ad, bn, bd, p, q, num, den;
        longint unsigned mn, md, x, y, t, qn, qd;
        longint   rn;
        ovf = 1'b0;
        zf  = 1'b0;
        an = longint'(s.a_num);
        ad = longint'(s.a_den);
        bn = longint'(s.b_num);
        bd = longint'(s.b_den);
        case (s.kind)
            KIND_ADD, KIND_SUB:
            begin
                p = wrap32(an * bd, ovf);
                q = wrap32(bn * ad, ovf);
                if (s.kind == KIND_SUB)
                    q = neg32(q, ovf);
                num = add32(p, q, ovf);
                den = wrap32(ad * bd, ovf);
            end
            KIND_MUL:
            begin
                num = wrap32(an * bn, ovf);
                den = wrap32(ad * bd, ovf);
            end
            KIND_DIV:
            begin
                num = wrap32(an * bd, ovf);
                den = wrap32(ad * bn, ovf);
            end
            KIND_NEG:
            begin
                num = neg32(an, ovf);
                den = ad;
            end
            default:
            begin
                num = an;
                den = ad;
            end
        endcase
        if (den == 0)
        begin
            den = 1;
            zf  = 1'b1;
        end
        mn = (num < 0) ? longint'(-num) : longint'(num);
        md = (den < 0) ? longint'(-den) : longint'(den);
        x = mn;
        y = md;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        qn = mn / x;
        qd = md / x;
        if ((num < 0) != (den < 0))
            rn = -longint'(qn);
        else
        begin
            rn = longint'(qn);
            if (qn == 64'h8000_0000)
                ovf = 1'b1;
        end
        if (qd >= 64'h8000_0000)
            ovf = 1'b1;
        r.res_num  = rn[31:0];
        r.res_den  = qd[30:0];
        r.zero_den = zf;
        r.overflow = ovf;
        return r;
    endfunction

    // operand shapes: full range, small signed, products with common factors, or extremes
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(4))
            0, 1: v = $urandom;
            2: v = 32'($signed($urandom_range(40)) - 20);
            3: v = 32'($urandom_range(1, 60) * $urandom_range(1, 60) * $urandom_range(1, 12));
            default:
            begin
                case ($urandom_range(5))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h0000_0001;
                    4: v = 32'h0000_0000;
                    default: v = 32'h4000_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    // one beat: hold start until an edge sees busy low
    task automatic send_beat(input rau_in_t s, input logic typed, input rau_out_t want);
        start   <= 1'b1;
        in_data <= s;
        do
            @(posedge clk);
        while (busy);
        expected_fracs.push_back(typed ? want : reduce_fraction(s));
        beats_in++;
    endtask

    // random idle between beats, none in the quiet stretch
    task automatic maybe_idle(input int idx);
        if ((idx < 800 || idx > 1100) && $urandom_range(99) < 22)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // result checker: the strobe lasts one cycle and cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            beats_out++;
            if (out_data.zero_den)
                zero_den_seen++;
            if (out_data.overflow)
                overflow_seen++;
            if (expected_fracs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", out_data);
            end
            else
            begin
                rau_out_t w;
                w = expected_fracs.pop_front();
                if (w !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp num %0d den %0d zd %b ov %b,",
                                  " got num %0d den %0d zd %b ov %b"},
                                 w.res_num, w.res_den, w.zero_den, w.overflow,
                                 out_data.res_num, out_data.res_den,
                                 out_data.zero_den, out_data.overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        dir_row_t    rows[$];
        rau_in_t     s;
        int          wait_n;
        rows = '{
            // typed rows: zero numerator, zero denominator, extremes, small sums and signs
            '{'{KIND_NORM, 32'sd0, 32'sd5, 32'sd0, 32'sd1}, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b0}},
            '{'{KIND_NORM, 32'sd3, 32'sd0, 32'sd0, 32'sd1}, 1'b1, '{32'sd3, 31'd1, 1'b1, 1'b0}},
            '{'{KIND_NEG, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd1}, 1'b1,
              '{32'h8000_0000, 31'd1, 1'b0, 1'b1}},
            '{'{KIND_NORM, 32'sd6, -32'sd4, 32'sd0, 32'sd1}, 1'b1, '{-32'sd3, 31'd2, 1'b0, 1'b0}},
            '{'{KIND_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3}, 1'b1, '{32'sd5, 31'd6, 1'b0, 1'b0}},
            '{'{KIND_DIV, 32'sd1, 32'sd2, 32'sd0, 32'sd1}, 1'b1, '{32'sd1, 31'd1, 1'b1, 1'b0}},
            '{'{KIND_MUL, 32'h7fff_ffff, 32'sd1, 32'sd2, 32'sd1}, 1'b1,
              '{-32'sd2, 31'd1, 1'b0, 1'b1}},
            '{'{KIND_NORM, 32'sd5, 32'h8000_0000, 32'sd0, 32'sd1}, 1'b1,
              '{-32'sd5, 31'd0, 1'b0, 1'b1}},
            // predicted rows
            '{'{KIND_SUB, 32'sd3, 32'sd4, 32'sd1, 32'sd4}, 1'b0, '0},
            '{'{KIND_SUB, 32'h8000_0000, 32'sd1, 32'sd1, 32'sd1}, 1'b0, '0},
            '{'{KIND_ADD, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1}, 1'b0, '0},
            '{'{KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff}, 1'b0, '0},
            '{'{KIND_DIV, -32'sd6, 32'sd9, 32'sd4, -32'sd3}, 1'b0, '0},
            '{'{KIND_DIV, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff}, 1'b0, '0},
            '{'{KIND_NEG, 32'h7fff_ffff, 32'hffff_ffff, 32'sd0, 32'sd1}, 1'b0, '0},
            '{'{KIND_NEG, 32'sd0, 32'sd0, 32'sd7, 32'sd0}, 1'b0, '0},
            '{'{3'd6, 32'sd12, 32'sd18, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0},
            '{'{3'd7, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'sd0}, 1'b0, '0},
            '{'{KIND_NORM, 32'h7fff_ffff, 32'h7fff_ffff, 32'sd0, 32'sd1}, 1'b0, '0},
            '{'{KIND_NORM, 32'h8000_0000, 32'hffff_ffff, 32'sd0, 32'sd1}, 1'b0, '0}
        };
        cycles        = 0;
        mismatches    = 0;
        beats_in      = 0;
        beats_out     = 0;
        zero_den_seen = 0;
        overflow_seen = 0;
        start   = 1'b0;
        in_data = '0;
        rst_n   = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_beat(rows[i].stim, rows[i].typed, rows[i].want);
            maybe_idle(0);
        end

        for (int i = 0; i < RandItems; i++)
        begin
            s.kind  = 3'($urandom_range(7));
            s.a_num = pick_operand();
            s.a_den = pick_operand();
            s.b_num = pick_operand();
            s.b_den = ($urandom_range(7) == 0) ? 32'sd1 : pick_operand();
            send_beat(s, 1'b0, '0);
            maybe_idle(i);
        end
        start <= 1'b0;

        while (expected_fracs.size() != 0)
            @(posedge clk);
        wait_n = 0;
        while (wait_n < DrainWait)
        begin
            @(posedge clk);
            wait_n++;
        end

        $display("sent %0d beats, checked %0d results (%0d zero denominators, %0d overflows)",
                 beats_in, beats_out, zero_den_seen, overflow_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && beats_out == beats_in)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
